[sv/crcrv_pkg.sv]
// ----------------------------------------------------------------------------
// crcrv_pkg
// Shared types, constants and the byte-wide CRC-32 step for the record
// validator.
// ----------------------------------------------------------------------------
package crcrv_pkg;

    // Record layout and check values
    localparam logic [31:0] REC_MAGIC   = 32'h4A52_4450;
    localparam logic [7:0]  REC_VERSION = 8'd1;
    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;   // reflected CRC-32
    localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
    localparam logic [7:0]  ERASED_BYTE = 8'hFF;

    localparam int          POS_W       = 4;
    localparam logic [3:0]  MAGIC_LAST  = 4'd3;
    localparam logic [3:0]  VERSION_POS = 4'd4;
    localparam logic [3:0]  STAGE_POS   = 4'd5;
    localparam logic [3:0]  MASK_POS    = 4'd6;
    localparam logic [3:0]  SEQ_FIRST   = 4'd8;
    localparam logic [3:0]  SEQ_LAST    = 4'd11;
    localparam logic [3:0]  CRC_SPAN    = 4'd12;
    localparam logic [3:0]  LAST_POS    = 4'd15;

    // Configuration port
    localparam int          CFG_IDX_W   = 2;
    localparam int          CFG_DATA_W  = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_BEGUN_STAGE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAILED_STAGE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GARBAGE_ABSENT = 2'd2;

    localparam logic [7:0]  BEGUN_RESET  = 8'd1;
    localparam logic [7:0]  FAILED_RESET = 8'd2;

    typedef enum logic [1:0] {
        VERDICT_ABSENT  = 2'd0,
        VERDICT_VALID   = 2'd1,
        VERDICT_GARBAGE = 2'd2
    } t_verdict;

    // Control from the record tracker to the CRC unit
    typedef struct packed {
        logic start;    // byte zero: seed from the initial value
        logic update;   // fold the byte into the CRC
    } t_crc_ctl;

    // One reflected CRC-32 byte step, eight shift/xor stages
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            x = (x >> 1) ^ (CRC_POLY & {32{x[0]}});
        end
        return x;
    endfunction

endpackage

[sv/crcrv_in_if.sv]
// ----------------------------------------------------------------------------
// crcrv_in_if
// Byte channel into the validator: valid/ready plus one record byte.
// ----------------------------------------------------------------------------
interface crcrv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;

    modport source (output valid, output data_byte, output first_byte, input ready);
    modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

[sv/crcrv_out_if.sv]
// ----------------------------------------------------------------------------
// crcrv_out_if
// Verdict channel out of the validator: valid/ready plus the record summary.
// ----------------------------------------------------------------------------
interface crcrv_out_if;
    logic                valid;
    logic                ready;
    crcrv_pkg::t_verdict verdict;
    logic [7:0]          stage_value;
    logic [7:0]          failure_mask;
    logic [31:0]         sequence_number;
    logic                crc_matched;

    modport source (output valid, output verdict, output stage_value, output failure_mask,
                    output sequence_number, output crc_matched, input ready);
    modport sink   (input valid, input verdict, input stage_value, input failure_mask,
                    input sequence_number, input crc_matched, output ready);
endinterface

[sv/crc_checked_record_validator_top.sv]
// ----------------------------------------------------------------------------
// crc_checked_record_validator_top
// Journal record validator: judges a 16-byte record as absent, valid or
// garbage.
// ----------------------------------------------------------------------------
// Usage
//   i_in  : one record byte per transaction; first_byte marks byte zero and
//           drops any partial record. After byte 15 the next byte starts a
//           new record whether or not first_byte is set.
//   o_out : one transaction per complete record carrying the verdict, the
//           stage and failure-mask bytes, the sequence number and the CRC
//           match flag.
//   cfg   : i_cfg_we/i_cfg_idx/i_cfg_wdata write the accepted stage codes and
//           the garbage-as-absent flag; write only while the block is idle.
// Timing
//   One byte per cycle unless byte 15 is held (see Stall); the verdict is in
//   the output register the cycle after byte 15 is taken. The CRC unit folds
//   bytes 0 to 11 into a 32-bit register, one per cycle as they are taken;
//   the verdict compares sit between the record and output registers.
// Reset
//   Synchronous, active low: byte count to zero, CRC to all ones, erased
//   flag set, output empty, configuration registers to their defaults.
// Stall
//   Only the byte after byte 14 (even a restart) can wait: it is held while
//   a previous verdict is still pending and o_out.ready is low.
// ----------------------------------------------------------------------------
module crc_checked_record_validator_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    crcrv_in_if.sink                          i_in,
    crcrv_out_if.source                       o_out,
    input  logic                              i_cfg_we,
    input  logic [crcrv_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [crcrv_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import crcrv_pkg::*;

    // configuration
    logic [7:0]  r_begun_code;
    logic [7:0]  r_failed_code;
    logic        r_garbage_absent;

    // record tracking
    logic [POS_W-1:0] r_pos;
    logic             r_erased;
    logic [31:0]      r_magic;
    logic [7:0]       r_version;
    logic [7:0]       r_stage;
    logic [7:0]       r_mask;
    logic [31:0]      r_seq;
    logic [31:0]      r_scrc;
    logic [31:0]      crc_now;

    // output register
    logic        r_out_valid;
    t_verdict    r_verdict;
    logic [7:0]  r_out_stage;
    logic [7:0]  r_out_mask;
    logic [31:0] r_out_seq;
    logic        r_out_crc_ok;

    logic             in_fire;
    logic             out_fire;
    logic [POS_W-1:0] pos;
    logic             last;
    logic             n_erased;
    logic [31:0]      stored_crc;
    logic             crc_ok;
    logic             bad;
    t_verdict         n_verdict;
    t_crc_ctl         crc_ctl;

    // byte 15 is held back only while a finished verdict is still waiting
    assign i_in.ready = !(r_out_valid && !o_out.ready && (r_pos == LAST_POS));
    assign in_fire    = i_in.valid && i_in.ready;
    assign out_fire   = r_out_valid && o_out.ready;

    always_comb begin
        pos        = i_in.first_byte ? '0 : r_pos;
        last       = (pos == LAST_POS);
        n_erased   = ((pos == '0) ? 1'b1 : r_erased) && (i_in.data_byte == ERASED_BYTE);
        // last stored-CRC byte lands straight into the compare
        stored_crc = {i_in.data_byte, r_scrc[31:8]};
        crc_ok     = (~crc_now == stored_crc);
        bad        = (r_magic != REC_MAGIC) || (r_version != REC_VERSION) || !crc_ok ||
                     ((r_stage != r_begun_code) && (r_stage != r_failed_code));
        if (n_erased) begin
            n_verdict = VERDICT_ABSENT;
        end else if (bad) begin
            n_verdict = r_garbage_absent ? VERDICT_ABSENT : VERDICT_GARBAGE;
        end else begin
            n_verdict = VERDICT_VALID;
        end
        crc_ctl.start  = (pos == '0);
        crc_ctl.update = in_fire && (pos < CRC_SPAN);
    end

    crcrv_crc_unit u_crc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (crc_ctl),
        .i_data_byte (i_in.data_byte),
        .o_crc       (crc_now)
    );

    // configuration writes; indices past the list are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_begun_code     <= BEGUN_RESET;
            r_failed_code    <= FAILED_RESET;
            r_garbage_absent <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BEGUN_STAGE:    r_begun_code     <= i_cfg_wdata[7:0];
                CFG_FAILED_STAGE:   r_failed_code    <= i_cfg_wdata[7:0];
                CFG_GARBAGE_ABSENT: r_garbage_absent <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // record position and erased tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_erased <= 1'b1;
        end else if (in_fire) begin
            r_pos    <= pos + 1'b1;   // wraps to zero after byte 15
            r_erased <= n_erased;
        end
    end

    // field capture; every field is fully overwritten before it is judged
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            case (pos) inside
                [4'd0:MAGIC_LAST]:    r_magic   <= {i_in.data_byte, r_magic[31:8]};
                VERSION_POS:          r_version <= i_in.data_byte;
                STAGE_POS:            r_stage   <= i_in.data_byte;
                MASK_POS:             r_mask    <= i_in.data_byte;
                [SEQ_FIRST:SEQ_LAST]: r_seq     <= {i_in.data_byte, r_seq[31:8]};
                [CRC_SPAN:LAST_POS]:  r_scrc    <= {i_in.data_byte, r_scrc[31:8]};
                default: begin
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire && last) begin
            r_out_valid <= 1'b1;
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && last) begin
            r_verdict    <= n_verdict;
            r_out_stage  <= r_stage;
            r_out_mask   <= r_mask;
            r_out_seq    <= r_seq;
            r_out_crc_ok <= crc_ok;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.verdict         = r_verdict;
    assign o_out.stage_value     = r_out_stage;
    assign o_out.failure_mask    = r_out_mask;
    assign o_out.sequence_number = r_out_seq;
    assign o_out.crc_matched     = r_out_crc_ok;

endmodule

[sv/crcrv_crc_unit.sv]
// ----------------------------------------------------------------------------
// crcrv_crc_unit
// Running reflected CRC-32 register, one byte folded in per transaction.
// ----------------------------------------------------------------------------
module crcrv_crc_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  crcrv_pkg::t_crc_ctl i_ctl,
    input  logic [7:0]          i_data_byte,
    output logic [31:0]         o_crc
);
    import crcrv_pkg::*;

    logic [31:0] r_crc;
    logic [31:0] n_crc;

    always_comb begin
        n_crc = crc_byte(i_ctl.start ? CRC_INIT : r_crc, i_data_byte);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_INIT;
        end else if (i_ctl.update) begin
            r_crc <= n_crc;
        end
    end

    assign o_crc = r_crc;

endmodule

[sv/crcrv_checker.sv]
// ----------------------------------------------------------------------------
// crcrv_checker
// Port-level checks on the validator, attached to the top level by bind.
// ----------------------------------------------------------------------------
module crcrv_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  crcrv_pkg::t_verdict i_verdict,
    input  logic                i_crc_matched
);
    import crcrv_pkg::*;

    // no verdict straight out of reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("verdict shown right after reset");

    // a held verdict stays until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("verdict dropped while stalled");

    // only the three defined verdict codes appear
    a_verdict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_verdict == VERDICT_ABSENT || i_verdict == VERDICT_VALID ||
                         i_verdict == VERDICT_GARBAGE))
        else $error("undefined verdict code");

    // a valid record must have passed its CRC
    a_valid_needs_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_verdict == VERDICT_VALID) |-> i_crc_matched)
        else $error("valid verdict without CRC match");

    // a fresh verdict needs a byte taken in the cycle before
    a_verdict_from_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready))
        else $error("verdict appeared without an input transaction");

endmodule

bind crc_checked_record_validator_top crcrv_checker u_crcrv_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_verdict     (o_out.verdict),
    .i_crc_matched (o_out.crc_matched)
);

[dv/tb_crc_checked_record_validator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_crc_checked_record_validator_top
// Self-checking bench for the journal record validator. Streams 16-byte
// records (good, erased, corrupted, bad stage, truncated, noise) through the
// byte channel under random back-pressure on both sides, predicts every
// verdict with its own CRC-32 record tracker and checks each verdict
// transaction field by field.
// ----------------------------------------------------------------------------
module tb_crc_checked_record_validator_top;
    import crcrv_pkg::*;

    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned TAIL_CYCLES   = 10;
    localparam int unsigned STALL_LIMIT   = 3000;  // cycles without any transaction
    localparam int unsigned HOLD_AFTER    = 8;     // verdicts before the long hold-off
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned PHASES        = 6;
    localparam int unsigned PHASE_BYTES   = 200;

    typedef struct {
        logic [7:0] data;
        logic       first;
    } t_stream_byte;

    typedef struct {
        t_verdict    verdict;
        logic [7:0]  stage_value;
        logic [7:0]  failure_mask;
        logic [31:0] sequence_number;
        logic        crc_matched;
    } t_record_summary;

    // byte i of a record is element [i]
    typedef logic [15:0][7:0] t_rec_bytes;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [7:0]           i_cfg_wdata;

    crcrv_in_if  in_ch ();
    crcrv_out_if out_ch ();

    crc_checked_record_validator_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // Record tracker: our own copy of the validator state and settings
    // ------------------------------------------------------------------------
    logic [7:0]  code_begun   = BEGUN_RESET;
    logic [7:0]  code_failed  = FAILED_RESET;
    logic        fold_garbage = 1'b0;

    logic [3:0]  rec_pos       = '0;
    logic [31:0] crc_acc       = CRC_INIT;
    logic        erased_so_far = 1'b1;
    logic [31:0] magic_acc     = '0;
    logic [7:0]  version_seen  = '0;
    logic [7:0]  stage_seen    = '0;
    logic [7:0]  mask_seen     = '0;
    logic [31:0] seq_acc       = '0;
    logic [31:0] crc_field     = '0;

    t_stream_byte    byte_stream[$];         // bytes waiting for the driver
    t_record_summary expected_summaries[$];  // verdicts predicted, not yet seen

    int unsigned mismatches    = 0;
    int unsigned verdicts_seen = 0;
    int unsigned idle_cycles   = 0;
    int unsigned send_gap      = 0;
    int unsigned send_calm     = 0;
    int unsigned recv_stall    = 0;
    int unsigned recv_calm     = 0;
    int unsigned hold_left     = 0;

    // stimulus-side alignment tracking
    int unsigned gen_pos       = 0;
    int unsigned queued_total  = 0;

    // Reflected CRC-32, fed one data bit at a time (LSB first)
    function automatic logic [31:0] crc32_fold_byte(input logic [31:0] acc,
                                                    input logic [7:0]  b);
        logic [31:0] r;
        r = acc;
        for (int i = 0; i < 8; i++) begin
            if (r[0] ^ b[i])
                r = (r >> 1) ^ CRC_POLY;
            else
                r = r >> 1;
        end
        return r;
    endfunction

    task automatic clear_capture();
        rec_pos       = '0;
        crc_acc       = CRC_INIT;
        erased_so_far = 1'b1;
        magic_acc     = '0;
        version_seen  = '0;
        stage_seen    = '0;
        mask_seen     = '0;
        seq_acc       = '0;
        crc_field     = '0;
    endtask

    // Fold one accepted byte into the tracker; 'done' marks the last byte
    task automatic fold_record_byte(input logic [7:0] b, input logic first,
                                    output bit done, output t_record_summary sum);
        logic [3:0] pos;
        logic       crc_ok;
        logic       bad;
        if (first)
            clear_capture();
        pos = rec_pos;
        if (pos < CRC_SPAN)
            crc_acc = crc32_fold_byte(crc_acc, b);
        if (b != ERASED_BYTE)
            erased_so_far = 1'b0;

        if (pos <= MAGIC_LAST)
            magic_acc = {b, magic_acc[31:8]};
        else if (pos == VERSION_POS)
            version_seen = b;
        else if (pos == STAGE_POS)
            stage_seen = b;
        else if (pos == MASK_POS)
            mask_seen = b;
        else if (pos >= SEQ_FIRST && pos <= SEQ_LAST)
            seq_acc = {b, seq_acc[31:8]};
        else if (pos >= CRC_SPAN)
            crc_field = {b, crc_field[31:8]};
        // reserved byte only feeds the CRC and the erased check

        done = (pos == LAST_POS);
        sum  = '{VERDICT_ABSENT, 8'h00, 8'h00, 32'h0, 1'b0};
        if (!done) begin
            rec_pos = pos + 4'd1;
        end else begin
            crc_ok = ((~crc_acc) == crc_field);
            bad    = (magic_acc != REC_MAGIC) || (version_seen != REC_VERSION) || !crc_ok ||
                     (stage_seen != code_begun && stage_seen != code_failed);
            if (erased_so_far)
                sum.verdict = VERDICT_ABSENT;
            else if (bad)
                sum.verdict = fold_garbage ? VERDICT_ABSENT : VERDICT_GARBAGE;
            else
                sum.verdict = VERDICT_VALID;
            sum.stage_value     = stage_seen;
            sum.failure_mask    = mask_seen;
            sum.sequence_number = seq_acc;
            sum.crc_matched     = crc_ok;
            clear_capture();
        end
    endtask

    // Mostly no gap; now and then a long one, and occasional calm stretches
    function automatic int unsigned pick_gap(inout int unsigned calm);
        int unsigned roll;
        roll = $urandom_range(0, 999);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if (roll < 8) begin
            calm = $urandom_range(40, 160);
            return 0;
        end
        if (roll < 550)
            return 0;
        if (roll < 860)
            return $urandom_range(1, 3);
        if (roll < 960)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] data, input logic first);
        byte_stream.push_back('{data, first});
        queued_total++;
        if (first)
            gen_pos = 0;
        gen_pos = (gen_pos + 1) % 16;
    endtask

    // Byte zero gets first_byte forced when the stream is out of step
    task automatic push_record(input t_rec_bytes rec, input logic first0);
        push_byte(rec[0], first0 || (gen_pos != 0));
        for (int i = 1; i < 16; i++)
            push_byte(rec[i], 1'b0);
    endtask

    function automatic t_rec_bytes build_record(input logic [7:0]  stage,
                                                input logic [7:0]  mask,
                                                input logic [7:0]  reserved,
                                                input logic [31:0] seq);
        t_rec_bytes  rec;
        logic [31:0] crc;
        rec[0]  = REC_MAGIC[7:0];
        rec[1]  = REC_MAGIC[15:8];
        rec[2]  = REC_MAGIC[23:16];
        rec[3]  = REC_MAGIC[31:24];
        rec[4]  = REC_VERSION;
        rec[5]  = stage;
        rec[6]  = mask;
        rec[7]  = reserved;
        rec[8]  = seq[7:0];
        rec[9]  = seq[15:8];
        rec[10] = seq[23:16];
        rec[11] = seq[31:24];
        crc = CRC_INIT;
        for (int i = 0; i < 12; i++)
            crc = crc32_fold_byte(crc, rec[i]);
        crc = ~crc;
        rec[12] = crc[7:0];
        rec[13] = crc[15:8];
        rec[14] = crc[23:16];
        rec[15] = crc[31:24];
        return rec;
    endfunction

    function automatic t_rec_bytes good_record();
        logic [7:0]  stage;
        logic [31:0] seq;
        stage = $urandom_range(0, 1) ? code_begun : code_failed;
        case ($urandom_range(0, 3))
            0:       seq = 32'h0000_0000;
            1:       seq = 32'hFFFF_FFFF;
            default: seq = $urandom;
        endcase
        return build_record(stage, 8'($urandom), 8'($urandom), seq);
    endfunction

    // Random records: under half well-formed, the rest broken or noise
    task automatic fill_random(input int unsigned n_bytes);
        int unsigned start;
        int unsigned roll;
        int unsigned k;
        t_rec_bytes  rec;
        start = queued_total;
        while (queued_total - start < n_bytes) begin
            roll = $urandom_range(0, 99);
            if (roll < 35) begin
                push_record(good_record(), 1'($urandom_range(0, 1)));
            end else if (roll < 45) begin
                // stage byte anywhere in its range, CRC still correct
                rec = build_record(8'($urandom), 8'($urandom), 8'($urandom), $urandom);
                push_record(rec, 1'($urandom_range(0, 1)));
            end else if (roll < 60) begin
                // one bit flipped in any of the 16 bytes, CRC field included
                rec = good_record();
                k   = $urandom_range(0, 127);
                rec[k / 8][k % 8] = ~rec[k / 8][k % 8];
                push_record(rec, 1'($urandom_range(0, 1)));
            end else if (roll < 68) begin
                rec = '1;                       // erased flash
                push_record(rec, 1'($urandom_range(0, 1)));
            end else if (roll < 74) begin
                rec = '1;                       // erased but for one byte
                rec[$urandom_range(0, 15)] = 8'($urandom_range(0, 254));
                push_record(rec, 1'($urandom_range(0, 1)));
            end else if (roll < 82) begin
                // truncated record; the next one restarts it mid-way
                rec = good_record();
                k   = $urandom_range(1, 15);
                push_byte(rec[0], 1'b1);
                for (int i = 1; i < k; i++)
                    push_byte(rec[i], 1'b0);
            end else if (roll < 88) begin
                k = $urandom_range(1, 20);
                for (int i = 0; i < k; i++)
                    push_byte(8'($urandom), 1'($urandom_range(0, 7) == 0));
            end else begin
                rec = {$urandom, $urandom, $urandom, $urandom};
                push_record(rec, 1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        case (idx)
            CFG_BEGUN_STAGE:    code_begun   = value;
            CFG_FAILED_STAGE:   code_failed  = value;
            CFG_GARBAGE_ABSENT: fold_garbage = value[0];
            default: ;
        endcase
    endtask

    // Everything queued has been taken and every predicted verdict seen
    task automatic wait_drained();
        while (byte_stream.size() != 0 || in_ch.valid || expected_summaries.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Clock and known values from time zero
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = '0;
        i_cfg_wdata      = '0;
        in_ch.valid      = 1'b0;
        in_ch.data_byte  = '0;
        in_ch.first_byte = 1'b0;
        out_ch.ready     = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Byte driver: takes bytes from the stream queue, predicts on acceptance
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_stream_byte    nxt;
        bit              done;
        t_record_summary sum;
        if (!i_rst_n) begin
            in_ch.valid      <= 1'b0;
            in_ch.data_byte  <= 8'h00;
            in_ch.first_byte <= 1'b0;
            send_gap = pick_gap(send_calm);
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_ch.valid) begin
                // transaction taken at this edge
                fold_record_byte(in_ch.data_byte, in_ch.first_byte, done, sum);
                if (done)
                    expected_summaries.push_back(sum);
                send_gap = pick_gap(send_calm);
            end
            if (send_gap == 0 && byte_stream.size() != 0) begin
                nxt = byte_stream.pop_front();
                in_ch.valid      <= 1'b1;
                in_ch.data_byte  <= nxt.data;
                in_ch.first_byte <= nxt.first;
            end else begin
                if (send_gap > 0)
                    send_gap--;
                // junk on the payload while idle
                in_ch.valid      <= 1'b0;
                in_ch.data_byte  <= 8'($urandom);
                in_ch.first_byte <= 1'($urandom);
            end
        end
        // otherwise hold the offered byte until it is taken
    end

    // ------------------------------------------------------------------------
    // Verdict monitor: random back-pressure plus one long hold-off so the
    // output fills and byte 15 of a later record has to wait
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_record_summary want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_summaries.size() == 0) begin
                    $display("%0t: verdict transaction with none expected: verdict %0d",
                             $time, out_ch.verdict);
                    mismatches++;
                end else begin
                    want = expected_summaries.pop_front();
                    if (out_ch.verdict !== want.verdict) begin
                        $display("%0t: verdict expected %0d actual %0d",
                                 $time, want.verdict, out_ch.verdict);
                        mismatches++;
                    end
                    if (out_ch.stage_value !== want.stage_value) begin
                        $display("%0t: stage_value expected %02h actual %02h",
                                 $time, want.stage_value, out_ch.stage_value);
                        mismatches++;
                    end
                    if (out_ch.failure_mask !== want.failure_mask) begin
                        $display("%0t: failure_mask expected %02h actual %02h",
                                 $time, want.failure_mask, out_ch.failure_mask);
                        mismatches++;
                    end
                    if (out_ch.sequence_number !== want.sequence_number) begin
                        $display("%0t: sequence_number expected %08h actual %08h",
                                 $time, want.sequence_number, out_ch.sequence_number);
                        mismatches++;
                    end
                    if (out_ch.crc_matched !== want.crc_matched) begin
                        $display("%0t: crc_matched expected %0b actual %0b",
                                 $time, want.crc_matched, out_ch.crc_matched);
                        mismatches++;
                    end
                end
                verdicts_seen++;
                if (verdicts_seen == HOLD_AFTER)
                    hold_left = HOLD_CYCLES;
            end

            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                out_ch.ready <= 1'b0;
            end else begin
                recv_stall = pick_gap(recv_calm);
                out_ch.ready <= (recv_stall == 0);
                if (recv_stall > 0)
                    recv_stall--;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long with no transaction on either channel
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (in_ch.valid && in_ch.ready) ||
            (out_ch.valid && out_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: reset, directed bytes, then phases of random records, each
    // phase under its own register settings (written only while idle)
    // ------------------------------------------------------------------------
    initial begin
        logic [7:0] set_begun;
        logic [7:0] set_failed;
        logic       set_fold;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 0) begin
                // partial record with extreme bytes, then a restart into a
                // good record with all-ones mask and sequence, reset codes
                push_byte(8'h00, 1'b1);
                push_byte(8'hFF, 1'b0);
                push_byte(8'h80, 1'b0);
                push_record(build_record(BEGUN_RESET, 8'hFF, 8'h00, 32'hFFFF_FFFF), 1'b1);
            end else begin
                wait_drained();
                // a dangling partial record may still be in flight
                repeat (SETTLE_CYCLES) @(posedge i_clk);
                case (ph)
                    1: begin
                        set_begun  = 8'h00;
                        set_failed = 8'hFF;
                        set_fold   = 1'b1;
                    end
                    2: begin
                        set_begun  = 8'hFF;
                        set_failed = 8'h00;
                        set_fold   = 1'b0;
                    end
                    3: begin
                        // both codes the same
                        set_begun  = 8'($urandom);
                        set_failed = set_begun;
                        set_fold   = 1'($urandom);
                    end
                    4: begin
                        set_begun  = 8'($urandom);
                        set_failed = 8'($urandom);
                        set_fold   = 1'($urandom);
                    end
                    default: begin
                        set_begun  = BEGUN_RESET;
                        set_failed = FAILED_RESET;
                        set_fold   = 1'b1;
                    end
                endcase
                write_setting(CFG_BEGUN_STAGE, set_begun);
                write_setting(CFG_FAILED_STAGE, set_failed);
                // upper bits of the flag write are don't-care
                write_setting(CFG_GARBAGE_ABSENT, {7'($urandom), set_fold});
                @(posedge i_clk);
                i_cfg_we <= 1'b0;
            end
            fill_random(PHASE_BYTES);
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_summaries.size() != 0) begin
            $display("%0t: %0d verdicts never arrived", $time, expected_summaries.size());
            mismatches++;
        end

        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[filelist.f]
sv/crcrv_pkg.sv
sv/crcrv_in_if.sv
sv/crcrv_out_if.sv
sv/crcrv_crc_unit.sv
sv/crc_checked_record_validator_top.sv
sv/crcrv_checker.sv
dv/tb_crc_checked_record_validator_top.sv
